FILE: sv/ordered_list_engine_macros.svh
// ===========================================================================
// Ordered list engine assertion macros
// Shared assertion forms for the list engine modules.
// ===========================================================================
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define OLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ole_pkg.sv
// ===========================================================================
// Ordered list engine package
// Shared codes, widths and constants of the list engine.
// ===========================================================================
package ole_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 7;
  localparam int unsigned CntW = 7;
  localparam int unsigned ReqW = 4;
  localparam int unsigned StW = 3;
  // Slot address width of the largest pool.
  localparam int unsigned SlotW = 6;

  // Request codes.
  localparam logic [ReqW-1:0] ReqInsFirst = 4'd0;
  localparam logic [ReqW-1:0] ReqInsLast  = 4'd1;
  localparam logic [ReqW-1:0] ReqInsPos   = 4'd2;
  localparam logic [ReqW-1:0] ReqDelFirst = 4'd3;
  localparam logic [ReqW-1:0] ReqDelLast  = 4'd4;
  localparam logic [ReqW-1:0] ReqDelPos   = 4'd5;
  localparam logic [ReqW-1:0] ReqDelValue = 4'd6;
  localparam logic [ReqW-1:0] ReqReverse  = 4'd7;
  localparam logic [ReqW-1:0] ReqDump     = 4'd8;

  // Status codes.
  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StFull     = 3'd1;
  localparam logic [StW-1:0] StEmpty    = 3'd2;
  localparam logic [StW-1:0] StBadPos   = 3'd3;
  localparam logic [StW-1:0] StNotFound = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_WALK_WAIT,
    S_LINK,
    S_RELINK_WAIT,
    S_REV_WAIT,
    S_DUMP_WAIT,
    S_INIT,
    S_OUT
  } state_e;

  // Memory access request toward the slot store.
  typedef struct packed {
    logic             rd;
    logic [SlotW-1:0] rd_addr;
    logic             wr_val;
    logic             wr_lnk;
    logic [SlotW-1:0] wr_addr;
    logic [31:0]      wval;
    logic [6:0]       wlnk;
  } mem_req_t;

endpackage

FILE: sv/ole_slot_mem.sv
// ===========================================================================
// Ordered list engine slot store
// Value and link memories, one write and one registered read per cycle.
// ===========================================================================
module ole_slot_mem #(
  parameter int unsigned Capacity = ole_pkg::CapacityDef,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic                 wr_val_i,
  input  logic                 wr_lnk_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic [31:0]          wval_i,
  input  logic [6:0]           wlnk_i,
  output logic [31:0]          rval_o,
  output logic [6:0]           rlnk_o
);

  logic [31:0] val_mem [Capacity];
  logic [6:0]  lnk_mem [Capacity];

  // Write ports.
  always_ff @(posedge clk_i) begin
    if (wr_val_i) val_mem[wr_addr_i] <= wval_i;
    if (wr_lnk_i) lnk_mem[wr_addr_i] <= wlnk_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      rval_o <= val_mem[rd_addr_i];
      rlnk_o <= lnk_mem[rd_addr_i];
    end
  end

endmodule

FILE: sv/ole_free_stack.sv
// ===========================================================================
// Ordered list engine free slot stack
// Stack of free slot indices in a memory, filled by a pass after reset.
// ===========================================================================
module ole_free_stack #(
  parameter int unsigned Capacity = ole_pkg::CapacityDef,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [AddrW-1:0] push_slot_i,
  input  logic             pop_i,
  output logic [AddrW-1:0] top_slot_o,
  output logic             ready_o
);

  logic [AddrW-1:0] stk_mem [Capacity];
  logic [AddrW:0]   top_q, top_d;
  logic [AddrW:0]   init_q, init_d;
  logic             init_done_q;
  logic [AddrW-1:0] top_rd_q;
  logic [AddrW:0]   rd_ptr;

  assign ready_o = init_done_q;

  // Stack pointer and init sweep.
  always_comb begin
    top_d  = top_q;
    init_d = init_q;
    if (!init_done_q) begin
      init_d = init_q + 1'b1;
    end else if (push_i) begin
      top_d = top_q + 1'b1;
    end else if (pop_i) begin
      top_d = top_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= (AddrW+1)'(Capacity);
      init_q      <= '0;
      init_done_q <= 1'b0;
    end else begin
      top_q  <= top_d;
      init_q <= init_d;
      if (!init_done_q && init_q == (AddrW+1)'(Capacity - 1)) init_done_q <= 1'b1;
    end
  end

  // Memory write: init fills entry i with Capacity-1-i.
  always_ff @(posedge clk_i) begin
    if (!init_done_q) begin
      stk_mem[init_q[AddrW-1:0]] <= AddrW'((AddrW+1)'(Capacity - 1) - init_q);
    end else if (push_i) begin
      stk_mem[top_q[AddrW-1:0]] <= push_slot_i;
    end
  end

  // Top entry read, registered; pointer of the new top is read ahead.
  assign rd_ptr = top_d - 1'b1;
  always_ff @(posedge clk_i) begin
    top_rd_q <= stk_mem[rd_ptr[AddrW-1:0]];
  end

  // A push writes the new top this same edge; the read then sees the old
  // content, so forward it.
  logic             fwd_q;
  logic [AddrW-1:0] fwd_slot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else         fwd_q <= init_done_q && push_i;
  end
  always_ff @(posedge clk_i) fwd_slot_q <= push_slot_i;

  assign top_slot_o = fwd_q ? fwd_slot_q : top_rd_q;

endmodule

FILE: sv/ole_ctrl.sv
// ===========================================================================
// Ordered list engine controller
// Decodes requests, walks the links and sequences memory updates.
// ===========================================================================
`include "ordered_list_engine_macros.svh"

module ole_ctrl #(
  parameter int unsigned Capacity = ole_pkg::CapacityDef,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             req_type_i,
  input  logic [6:0]             position_i,
  input  logic [31:0]            value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [31:0]            element_o,
  output logic [6:0]             count_o,
  output logic                   last_o,
  output ole_pkg::mem_req_t      mem_o,
  input  logic [31:0]            rval_i,
  input  logic [6:0]             rlnk_i,
  output logic                   push_o,
  output logic [AddrW-1:0]       push_slot_o,
  output logic                   pop_o,
  input  logic [AddrW-1:0]       free_slot_i,
  input  logic                   init_done_i
);

  localparam logic [6:0] NullLink = 7'd127;
  localparam int unsigned SlotW = ole_pkg::SlotW;

  ole_pkg::state_e state_q, state_d;

  logic [3:0]  req_q;
  logic [6:0]  pos_q;
  logic [31:0] val_q;
  logic [6:0]  head_q, head_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [6:0]  idx_q, idx_d;        // walk step counter
  logic [6:0]  target_q, target_d;  // walk index of predecessor (insert) or victim (delete)
  logic [6:0]  cur_q, cur_d;        // current slot
  logic [6:0]  prev_q, prev_d;      // predecessor slot
  logic        acc_q;

  // Output register.
  logic        ovalid_q, ovalid_d;
  logic [2:0]  ost_q, ost_d;
  logic [31:0] oel_q, oel_d;
  logic        olast_q, olast_d;
  logic        finish_d;

  logic in_fire, out_fire;
  assign in_ready_o = (state_q == ole_pkg::S_IDLE) && init_done_i && !ovalid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = ovalid_q && out_ready_i;

  assign out_valid_o = ovalid_q;
  assign status_o    = ost_q;
  assign element_o   = oel_q;
  assign count_o     = cnt_q;
  assign last_o      = olast_q;

  logic is_ins, is_del;
  assign is_ins = (req_q == ole_pkg::ReqInsFirst) || (req_q == ole_pkg::ReqInsLast) ||
                  (req_q == ole_pkg::ReqInsPos);
  assign is_del = (req_q == ole_pkg::ReqDelFirst) || (req_q == ole_pkg::ReqDelLast) ||
                  (req_q == ole_pkg::ReqDelPos) || (req_q == ole_pkg::ReqDelValue);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ole_pkg::S_IDLE:        if (in_fire) state_d = ole_pkg::S_DECIDE;
      ole_pkg::S_DECIDE: begin
        // A dump has its head read in flight already.
        if (finish_d) state_d = ole_pkg::S_OUT;
        else if (req_q == ole_pkg::ReqDump) state_d = ole_pkg::S_DUMP_WAIT;
        else state_d = ole_pkg::S_WALK;
      end
      ole_pkg::S_WALK:        state_d = ole_pkg::S_WALK_WAIT;
      ole_pkg::S_WALK_WAIT:   state_d = finish_d ? ole_pkg::S_OUT : ole_pkg::S_WALK;
      ole_pkg::S_LINK:        state_d = ole_pkg::S_RELINK_WAIT;
      ole_pkg::S_RELINK_WAIT: state_d = ole_pkg::S_OUT;
      ole_pkg::S_REV_WAIT:    state_d = finish_d ? ole_pkg::S_OUT : ole_pkg::S_WALK;
      ole_pkg::S_DUMP_WAIT:   state_d = finish_d ? ole_pkg::S_OUT : ole_pkg::S_DUMP_WAIT;
      ole_pkg::S_INIT:        state_d = ole_pkg::S_IDLE;
      ole_pkg::S_OUT:         state_d = ole_pkg::S_OUT;
      default:                state_d = ole_pkg::S_IDLE;
    endcase
    if (state_q == ole_pkg::S_WALK_WAIT && acc_q) state_d = ole_pkg::S_LINK;
    if (state_q == ole_pkg::S_OUT && (!ovalid_q || out_fire))
      state_d = olast_q ? ole_pkg::S_IDLE : ole_pkg::S_DUMP_WAIT;
    if (state_q == ole_pkg::S_DUMP_WAIT && !finish_d) state_d = ole_pkg::S_DUMP_WAIT;
  end

  // Datapath and outputs.
  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    target_d = target_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    ovalid_d = ovalid_q;
    ost_d    = ost_q;
    oel_d    = oel_q;
    olast_d  = olast_q;
    finish_d = 1'b0;
    mem_o    = '0;
    push_o   = 1'b0;
    pop_o    = 1'b0;
    push_slot_o = cur_q[AddrW-1:0];

    if (out_fire) ovalid_d = 1'b0;

    unique case (state_q)
      ole_pkg::S_IDLE: begin
      end
      ole_pkg::S_DECIDE: begin
        // Defaults for a one-result request.
        ost_d   = ole_pkg::StOk;
        oel_d   = '0;
        olast_d = 1'b1;
        idx_d   = '0;
        cur_d   = head_q;
        prev_d  = NullLink;
        finish_d = 1'b1;
        if (is_ins) begin
          if (cnt_q >= 7'(Capacity)) begin
            ost_d = ole_pkg::StFull;
          end else if (req_q == ole_pkg::ReqInsFirst ||
                       (req_q == ole_pkg::ReqInsPos && pos_q == 7'd1)) begin
            // Front insert needs no walk.
            mem_o.wr_val  = 1'b1;
            mem_o.wr_lnk  = 1'b1;
            mem_o.wr_addr = SlotW'(free_slot_i);
            mem_o.wval    = val_q;
            mem_o.wlnk    = head_q;
            head_d        = 7'(free_slot_i);
            pop_o         = 1'b1;
            cnt_d         = cnt_q + 1'b1;
          end else if (req_q == ole_pkg::ReqInsPos &&
                       (pos_q == 7'd0 || pos_q > cnt_q + 7'd1)) begin
            ost_d = ole_pkg::StBadPos;
          end else if (req_q == ole_pkg::ReqInsLast && cnt_q == 7'd0) begin
            mem_o.wr_val  = 1'b1;
            mem_o.wr_lnk  = 1'b1;
            mem_o.wr_addr = SlotW'(free_slot_i);
            mem_o.wval    = val_q;
            mem_o.wlnk    = head_q;
            head_d        = 7'(free_slot_i);
            pop_o         = 1'b1;
            cnt_d         = cnt_q + 1'b1;
          end else begin
            // Walk to the predecessor at position k-1, index k-2.
            target_d = (req_q == ole_pkg::ReqInsLast) ? cnt_q - 7'd1 : pos_q - 7'd2;
            finish_d = 1'b0;
          end
        end else if (is_del) begin
          if (cnt_q == 7'd0) begin
            ost_d = ole_pkg::StEmpty;
          end else if (req_q == ole_pkg::ReqDelPos && (pos_q == 7'd0 || pos_q > cnt_q)) begin
            ost_d = ole_pkg::StBadPos;
          end else begin
            // Every delete walks; target is the index of the victim, or 127 when deleting by value.
            unique case (req_q)
              ole_pkg::ReqDelFirst: target_d = 7'd0;
              ole_pkg::ReqDelLast:  target_d = cnt_q - 7'd1;
              ole_pkg::ReqDelPos:   target_d = pos_q - 7'd1;
              default:              target_d = 7'd127;
            endcase
            finish_d = 1'b0;
          end
        end else if (req_q == ole_pkg::ReqReverse) begin
          if (cnt_q != 7'd0) finish_d = 1'b0;
        end else if (req_q == ole_pkg::ReqDump) begin
          if (cnt_q == 7'd0) ost_d = ole_pkg::StEmpty;
          else finish_d = 1'b0;
        end
        if (finish_d) ovalid_d = 1'b1;
        if (!finish_d && req_q == ole_pkg::ReqDump) begin
          mem_o.rd      = 1'b1;
          mem_o.rd_addr = SlotW'(head_q[AddrW-1:0]);
        end
      end
      ole_pkg::S_WALK: begin
        // Read the current slot.
        mem_o.rd      = 1'b1;
        mem_o.rd_addr = SlotW'(cur_q[AddrW-1:0]);
      end
      ole_pkg::S_WALK_WAIT: begin
        if (is_ins) begin
          // cur is the node at idx; stop once idx reaches the target.
          if (idx_q == target_q) begin
            mem_o.wr_val  = 1'b1;
            mem_o.wr_lnk  = 1'b1;
            mem_o.wr_addr = SlotW'(free_slot_i);
            mem_o.wval    = val_q;
            mem_o.wlnk    = rlnk_i;
            pop_o         = 1'b1;
            prev_d        = cur_q;
            cur_d         = 7'(free_slot_i);
          end else begin
            idx_d = idx_q + 1'b1;
            cur_d = rlnk_i;
          end
        end else if (req_q == ole_pkg::ReqReverse) begin
          mem_o.wr_lnk  = 1'b1;
          mem_o.wr_addr = SlotW'(cur_q[AddrW-1:0]);
          mem_o.wlnk    = prev_q;
          prev_d        = cur_q;
          cur_d         = rlnk_i;
          idx_d         = idx_q + 1'b1;
          if (idx_q + 7'd1 == cnt_q) begin
            head_d   = cur_q;
            finish_d = 1'b1;
            ovalid_d = 1'b1;
          end
        end else begin
          // Delete walk: cur is node idx, prev its predecessor.
          if (idx_q == target_q ||
              (req_q == ole_pkg::ReqDelValue && rval_i == val_q)) begin
            oel_d = rval_i;
            if (prev_q == NullLink) begin
              head_d = rlnk_i;
            end else begin
              mem_o.wr_lnk  = 1'b1;
              mem_o.wr_addr = SlotW'(prev_q[AddrW-1:0]);
              mem_o.wlnk    = rlnk_i;
            end
            push_o      = 1'b1;
            push_slot_o = cur_q[AddrW-1:0];
            cnt_d       = cnt_q - 1'b1;
            finish_d    = 1'b1;
            ovalid_d    = 1'b1;
          end else if (idx_q + 7'd1 == cnt_q) begin
            ost_d    = ole_pkg::StNotFound;
            finish_d = 1'b1;
            ovalid_d = 1'b1;
          end else begin
            idx_d  = idx_q + 1'b1;
            prev_d = cur_q;
            cur_d  = rlnk_i;
          end
        end
      end
      ole_pkg::S_LINK: begin
        // Link predecessor to the new slot.
        mem_o.wr_lnk  = 1'b1;
        mem_o.wr_addr = SlotW'(prev_q[AddrW-1:0]);
        mem_o.wlnk    = cur_q;
        cnt_d         = cnt_q + 1'b1;
      end
      ole_pkg::S_RELINK_WAIT: begin
        ovalid_d = 1'b1;
      end
      ole_pkg::S_REV_WAIT: begin
      end
      ole_pkg::S_DUMP_WAIT: begin
        // Read data of cur is present: show it.
        ost_d    = ole_pkg::StOk;
        oel_d    = rval_i;
        olast_d  = (idx_q + 7'd1 == cnt_q);
        cur_d    = rlnk_i;
        idx_d    = idx_q + 1'b1;
        ovalid_d = 1'b1;
        finish_d = 1'b1;
      end
      ole_pkg::S_INIT: begin
      end
      ole_pkg::S_OUT: begin
        // Next dump element read issued while the result leaves.
        if ((!ovalid_q || out_fire) && !olast_q) begin
          mem_o.rd      = 1'b1;
          mem_o.rd_addr = SlotW'(cur_q[AddrW-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // Walk-done flag for inserts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= (state_q == ole_pkg::S_WALK) && is_ins && (idx_q == target_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ole_pkg::S_IDLE;
      head_q   <= NullLink;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    idx_q    <= idx_d;
    target_q <= target_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    ost_q    <= ost_d;
    oel_q    <= oel_d;
    olast_q  <= olast_d;
  end

  `OLE_ASSERT(a_cnt_range, cnt_q <= 7'(Capacity), "count above capacity")
  `OLE_ASSERT(a_no_push_pop, !(push_o && pop_o), "push and pop together")
  `OLE_ASSERT_NEXT(a_hold_out, ovalid_q && !out_ready_i, ovalid_q, "result dropped")
  `OLE_ASSERT(a_idle_ready, !(in_ready_o && ovalid_q), "accept with pending result")

endmodule

FILE: sv/ordered_list_engine.sv
// ===========================================================================
// Ordered list engine
// Bounded singly linked list of signed values in a pool of linked slots.
// ===========================================================================
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: req_type[3:0], position[10:4], value[42:11]
//  m_axis   | out       | tdata: status[2:0], element[34:3], count[41:35]; tlast: last
//
// One request at a time. Front inserts and requests rejected on decode need
// no walk; walking requests step one slot at a time, each step a registered
// memory read then an update. Dump gives its results one by one, reading the
// next element as each result leaves. After reset the free-slot stack is
// filled before the first request is taken. Either side may stall.
module ordered_list_engine #(
  parameter int unsigned CAPACITY = ole_pkg::CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // req_type, position, value, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status, element, count, zero fill
  output logic        m_axis_tlast    // last
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ole_pkg::mem_req_t mem_req;
  logic [31:0]       rval;
  logic [6:0]        rlnk;
  logic              push, pop, init_done;
  logic [AddrW-1:0]  push_slot, free_slot;
  logic [2:0]        status;
  logic [31:0]       element;
  logic [6:0]        count;

  assign m_axis_tdata = {6'd0, count, element, status};

  ole_ctrl #(.Capacity(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tdata[3:0]),
    .position_i  (s_axis_tdata[10:4]),
    .value_i     (s_axis_tdata[42:11]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .element_o   (element),
    .count_o     (count),
    .last_o      (m_axis_tlast),
    .mem_o       (mem_req),
    .rval_i      (rval),
    .rlnk_i      (rlnk),
    .push_o      (push),
    .push_slot_o (push_slot),
    .pop_o       (pop),
    .free_slot_i (free_slot),
    .init_done_i (init_done)
  );

  ole_slot_mem #(.Capacity(CAPACITY)) u_mem (
    .clk_i,
    .rd_i      (mem_req.rd),
    .rd_addr_i (mem_req.rd_addr[AddrW-1:0]),
    .wr_val_i  (mem_req.wr_val),
    .wr_lnk_i  (mem_req.wr_lnk),
    .wr_addr_i (mem_req.wr_addr[AddrW-1:0]),
    .wval_i    (mem_req.wval),
    .wlnk_i    (mem_req.wlnk),
    .rval_o    (rval),
    .rlnk_o    (rlnk)
  );

  ole_free_stack #(.Capacity(CAPACITY)) u_free (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_slot_i (push_slot),
    .pop_i       (pop),
    .top_slot_o  (free_slot),
    .ready_o     (init_done)
  );

endmodule
